### hdl/olst_pkg.sv
// Shared types and codes for the indexed ordered list.
// Holds operation kinds, status codes, chain commands and control states.
// No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_REMOVE = 3'd1;
    localparam logic [2:0] K_GET    = 3'd2;
    localparam logic [2:0] K_FIND   = 3'd3;
    localparam logic [2:0] K_APPEND = 3'd4;
    localparam logic [2:0] K_DROP   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CH_IDLE,
        CH_INSERT,
        CH_REMOVE,
        CH_ROTATE
    } t_chain_op;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

### hdl/olst_cell.sv
// One storage cell of the list chain: holds one entry word.
// Takes from its left or right neighbour, the new word or the head word.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell #(
    parameter int W_CNT    = 5,
    parameter int CELL_POS = 0
) (
    input  logic                    i_clk,
    input  olst_pkg::t_chain_op     i_op,
    input  logic [W_CNT-1:0]        i_pos,
    input  logic [W_CNT-1:0]        i_count,
    input  logic signed [31:0]      i_new,
    input  logic signed [31:0]      i_left,
    input  logic signed [31:0]      i_right,
    input  logic signed [31:0]      i_head,
    output logic signed [31:0]      o_data
);
    import olst_pkg::*;

    localparam logic [W_CNT-1:0] L_POS  = W_CNT'(CELL_POS);
    localparam logic [W_CNT-1:0] L_NEXT = W_CNT'(CELL_POS + 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            CH_INSERT: begin
                if (L_POS == i_pos) begin
                    n_data = i_new;
                end else if (L_POS > i_pos && L_POS <= i_count) begin
                    n_data = i_left;
                end
            end
            CH_REMOVE: begin
                if (L_POS >= i_pos && L_NEXT < i_count) begin
                    n_data = i_right;
                end
            end
            CH_ROTATE: begin
                if (L_NEXT == i_count) begin
                    n_data = i_head;
                end else if (L_NEXT < i_count) begin
                    n_data = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### hdl/indexed_ordered_list_top.sv
// Top level of the indexed ordered list: chain of entry cells and its control.
// Depends on olst_pkg and olst_cell.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words, one cell per entry.
// A command is taken when start is high and busy is low; its single result
// appears on the o_ ports for one cycle with o_strobe high and must be taken
// then, as the block cannot be held off. Insert, remove and append shift the
// cell chain and drop only lowers the count: the result follows in the cycle
// after the command and busy stays low, so commands may be issued every cycle.
// Get and find rotate the chain once round the stored entries, reading (get)
// or comparing (find) the head cell each step: busy is high during the scan
// and the result follows its end. Get on a position out of range and find on
// an empty list answer without a scan. No clearing pass follows reset.

module indexed_ordered_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic [4:0]         i_index,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic               o_found,
    output logic [3:0]         o_position,
    output logic [4:0]         o_count
);
    import olst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 5) ? CW : 5;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_strobe, n_strobe;
    logic               r_is_get, n_is_get;
    logic [CW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_value, n_value;
    logic [CW-1:0]      r_step, n_step;
    logic               r_hit, n_hit;
    logic [CW-1:0]      r_hit_pos, n_hit_pos;
    logic signed [31:0] r_rd, n_rd;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_read, n_read;
    logic               r_found, n_found;
    logic [CW-1:0]      r_position, n_position;

    t_chain_op          ch_op;
    logic [CW-1:0]      ch_pos;
    logic signed [31:0] w_data [CAPACITY];
    logic signed [31:0] head;

    logic               accept;
    logic [IW-1:0]      idx_ext;
    logic [IW-1:0]      cnt_ext;
    logic [IW-1:0]      posn_ext;
    logic               is_full;
    logic               is_empty;
    logic [CW-1:0]      step_nx;
    logic               match;
    logic               found_now;
    logic [CW-1:0]      pos_now;
    logic signed [31:0] rd_now;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_data[0];
            end else begin : g_inner_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_inner_r
                assign w_right = w_data[g+1];
            end
            olst_cell #(
                .W_CNT    (CW),
                .CELL_POS (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (ch_op),
                .i_pos   (ch_pos),
                .i_count (r_count),
                .i_new   (i_value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (head),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    assign head      = w_data[0];
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign idx_ext   = IW'(i_index);
    assign cnt_ext   = IW'(r_count);
    assign is_full   = (r_count == CW'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign step_nx   = r_step + 1'b1;
    assign match     = (head == r_value);
    assign found_now = r_hit || match;
    assign pos_now   = r_hit ? r_hit_pos : r_step;
    assign rd_now    = (r_step == r_pos) ? head : r_rd;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_strobe   = 1'b0;
        n_is_get   = r_is_get;
        n_pos      = r_pos;
        n_value    = r_value;
        n_step     = r_step;
        n_hit      = r_hit;
        n_hit_pos  = r_hit_pos;
        n_rd       = r_rd;
        n_status   = r_status;
        n_read     = r_read;
        n_found    = r_found;
        n_position = r_position;
        ch_op      = CH_IDLE;
        ch_pos     = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe   = 1'b1;
                    n_status   = ST_OK;
                    n_read     = '0;
                    n_found    = 1'b0;
                    n_position = '0;
                    n_is_get   = (i_kind == K_GET);
                    n_pos      = CW'(i_index);
                    n_value    = i_value;
                    n_step     = '0;
                    n_hit      = 1'b0;
                    n_hit_pos  = '0;
                    n_rd       = '0;
                    unique case (i_kind)
                        K_INSERT: begin
                            if (idx_ext > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ch_op   = CH_INSERT;
                                ch_pos  = CW'(i_index);
                                n_count = r_count + 1'b1;
                            end
                        end
                        K_APPEND: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ch_op   = CH_INSERT;
                                ch_pos  = r_count;
                                n_count = r_count + 1'b1;
                            end
                        end
                        K_REMOVE: begin
                            if (idx_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                ch_op   = CH_REMOVE;
                                ch_pos  = CW'(i_index);
                                n_count = r_count - 1'b1;
                            end
                        end
                        K_GET: begin
                            if (idx_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        K_FIND: begin
                            if (!is_empty) begin
                                n_strobe = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        K_DROP: begin
                            if (is_empty) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ch_op     = CH_ROTATE;
                n_step    = step_nx;
                n_rd      = rd_now;
                n_hit     = found_now;
                n_hit_pos = pos_now;
                if (step_nx == r_count) begin
                    n_state    = S_IDLE;
                    n_strobe   = 1'b1;
                    n_status   = ST_OK;
                    n_read     = r_is_get ? rd_now : '0;
                    n_found    = !r_is_get && found_now;
                    n_position = (!r_is_get && found_now) ? pos_now : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_get   <= n_is_get;
        r_pos      <= n_pos;
        r_value    <= n_value;
        r_step     <= n_step;
        r_hit      <= n_hit;
        r_hit_pos  <= n_hit_pos;
        r_rd       <= n_rd;
        r_status   <= n_status;
        r_read     <= n_read;
        r_found    <= n_found;
        r_position <= n_position;
    end

    assign posn_ext     = IW'(r_position);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_read_value = r_read;
    assign o_found      = r_found;
    assign o_position   = posn_ext[3:0];
    assign o_count      = cnt_ext[4:0];

endmodule
